>>> rtl/lclf_pkg.sv
`timescale 1ns / 1ps

package lclf_pkg;

    // Width of the counter value. The divider constants below stay exact up to 12 bits.
    localparam int VALUE_BITS  = 10;
    localparam int CODE_BITS   = 12;
    localparam int STYLE_BITS  = 4;
    localparam int CFG_IDX_BITS = 1;
    localparam int MAX_RESULTS = 40;
    localparam int REM_BITS    = 5;

    // Decimal digits of the widest value, never fewer than the three Roman places.
    localparam int DEC_DIGITS  = (VALUE_BITS + 2) / 3;
    localparam int DIGIT_SLOTS = (DEC_DIGITS > 3) ? DEC_DIGITS : 3;
    localparam int SLOT_BITS   = $clog2(DIGIT_SLOTS);
    localparam int CNT_BITS    = $clog2(DIGIT_SLOTS + 1);
    localparam int REP_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int TH_MAX      = ((1 << VALUE_BITS) - 1) / 1000;
    localparam int TH_BITS     = $clog2(TH_MAX + 2);

    // Reciprocal multipliers: floor(x * RECIP >> SHIFT) equals floor(x / radix) for x < 4096.
    localparam int RECIP_BITS = 12;
    localparam int RECIP10    = 3277;
    localparam int SHIFT10    = 15;
    localparam int RECIP26    = 2521;
    localparam int SHIFT26    = 16;

    // Character codes.
    localparam logic [CODE_BITS-1:0] CODE_ZERO    = 12'h030;
    localparam logic [CODE_BITS-1:0] CODE_LOWER_A = 12'h061;
    localparam logic [CODE_BITS-1:0] CODE_UPPER_A = 12'h041;
    localparam logic [CODE_BITS-1:0] CODE_LOWER_M = 12'h06d;
    localparam logic [CODE_BITS-1:0] CASE_SHIFT   = 12'h020;

    // Label styles as held in the style register.
    localparam logic [STYLE_BITS-1:0] STYLE_DECIMAL     = 4'd0;
    localparam logic [STYLE_BITS-1:0] STYLE_LOWER_ALPHA = 4'd1;
    localparam logic [STYLE_BITS-1:0] STYLE_UPPER_ALPHA = 4'd2;
    localparam logic [STYLE_BITS-1:0] STYLE_LOWER_ROMAN = 4'd3;
    localparam logic [STYLE_BITS-1:0] STYLE_UPPER_ROMAN = 4'd4;
    localparam logic [STYLE_BITS-1:0] STYLE_BENGALI     = 4'd5;
    localparam logic [STYLE_BITS-1:0] STYLE_GUJARATI    = 4'd6;
    localparam logic [STYLE_BITS-1:0] STYLE_GURMUKHI    = 4'd7;
    localparam logic [STYLE_BITS-1:0] STYLE_KANNADA     = 4'd8;
    localparam logic [STYLE_BITS-1:0] STYLE_MALAYALAM   = 4'd9;
    localparam logic [STYLE_BITS-1:0] STYLE_ORIYA       = 4'd10;
    localparam logic [STYLE_BITS-1:0] STYLE_TAMIL       = 4'd11;
    localparam logic [STYLE_BITS-1:0] STYLE_TELUGU      = 4'd12;
    localparam logic [STYLE_BITS-1:0] STYLE_TIBETAN     = 4'd13;
    localparam logic [STYLE_BITS-1:0] STYLE_THAI        = 4'd14;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_LABEL_STYLE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LETTER_SYNC = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT_DIGITS,
        ST_EMIT_THOUSANDS,
        ST_EMIT_ROMAN,
        ST_EMIT_REPEAT
    } t_state;

    typedef enum logic [1:0] {
        MODE_DIGITS,
        MODE_ALPHA,
        MODE_ROMAN,
        MODE_SYNC
    } t_mode;

    typedef enum logic [1:0] {
        ROM_ONE,
        ROM_FIVE,
        ROM_TEN
    } t_roman_sym;

    typedef struct packed {
        logic [VALUE_BITS-1:0] dividend;
        logic                  radix26;
    } t_div_req;

    typedef struct packed {
        logic [VALUE_BITS-1:0] quot;
        logic [REM_BITS-1:0]   rem;
    } t_div_rsp;

    function automatic logic [CODE_BITS-1:0] script_zero(input logic [STYLE_BITS-1:0] style);
        logic [CODE_BITS-1:0] code;
        unique case (style)
            STYLE_BENGALI:   code = 12'h9e6;
            STYLE_GUJARATI:  code = 12'hae6;
            STYLE_GURMUKHI:  code = 12'ha66;
            STYLE_KANNADA:   code = 12'hce6;
            STYLE_MALAYALAM: code = 12'hd66;
            STYLE_ORIYA:     code = 12'hb66;
            STYLE_TAMIL:     code = 12'hbe6;
            STYLE_TELUGU:    code = 12'hc66;
            STYLE_TIBETAN:   code = 12'hf20;
            STYLE_THAI:      code = 12'he50;
            default:         code = CODE_ZERO;
        endcase
        return code;
    endfunction

    // Number of characters one Roman decimal place produces.
    function automatic logic [2:0] roman_len(input logic [REM_BITS-1:0] d);
        logic [2:0] len;
        unique case (d)
            5'd1, 5'd5:       len = 3'd1;
            5'd2, 5'd4, 5'd6, 5'd9: len = 3'd2;
            5'd3, 5'd7:       len = 3'd3;
            5'd8:             len = 3'd4;
            default:          len = 3'd0;
        endcase
        return len;
    endfunction

    // Which symbol stands at position j of a Roman place holding digit d.
    function automatic t_roman_sym roman_sym(input logic [REM_BITS-1:0] d, input logic [1:0] j);
        t_roman_sym sym;
        if (d == 5'd9) begin
            sym = (j == 2'd0) ? ROM_ONE : ROM_TEN;
        end else if (d == 5'd4) begin
            sym = (j == 2'd0) ? ROM_ONE : ROM_FIVE;
        end else if (d >= 5'd5) begin
            sym = (j == 2'd0) ? ROM_FIVE : ROM_ONE;
        end else begin
            sym = ROM_ONE;
        end
        return sym;
    endfunction

    function automatic logic [CODE_BITS-1:0] roman_char(input logic [1:0] place,
                                                        input t_roman_sym sym,
                                                        input logic upper);
        logic [7:0] lower;
        lower = 8'h69;
        unique case (place)
            2'd0: begin
                unique case (sym)
                    ROM_FIVE: lower = 8'h76;
                    ROM_TEN:  lower = 8'h78;
                    default:  lower = 8'h69;
                endcase
            end
            2'd1: begin
                unique case (sym)
                    ROM_FIVE: lower = 8'h6c;
                    ROM_TEN:  lower = 8'h63;
                    default:  lower = 8'h78;
                endcase
            end
            default: begin
                unique case (sym)
                    ROM_FIVE: lower = 8'h64;
                    ROM_TEN:  lower = 8'h6d;
                    default:  lower = 8'h63;
                endcase
            end
        endcase
        return upper ? (CODE_BITS'(lower) - CASE_SHIFT) : CODE_BITS'(lower);
    endfunction

endpackage

>>> rtl/lclf_divu.sv
`timescale 1ns / 1ps

// Shared divide-by-ten or divide-by-26 unit: reciprocal multiply, then the
// remainder by shift-and-add back-multiplication.
module lclf_divu (
    input  lclf_pkg::t_div_req i_req,
    output lclf_pkg::t_div_rsp o_rsp
);

    localparam int PROD_BITS = lclf_pkg::VALUE_BITS + lclf_pkg::RECIP_BITS;

    logic [lclf_pkg::RECIP_BITS-1:0] recip;
    logic [PROD_BITS-1:0]            prod;
    logic [lclf_pkg::VALUE_BITS-1:0] quot;
    logic [lclf_pkg::VALUE_BITS-1:0] back;
    logic [lclf_pkg::VALUE_BITS-1:0] diff;

    always_comb begin
        recip = i_req.radix26 ? lclf_pkg::RECIP_BITS'(lclf_pkg::RECIP26)
                              : lclf_pkg::RECIP_BITS'(lclf_pkg::RECIP10);
        prod  = PROD_BITS'(i_req.dividend) * PROD_BITS'(recip);
        if (i_req.radix26) begin
            quot = lclf_pkg::VALUE_BITS'(prod >> lclf_pkg::SHIFT26);
            back = (quot << 4) + (quot << 3) + (quot << 1);
        end else begin
            quot = lclf_pkg::VALUE_BITS'(prod >> lclf_pkg::SHIFT10);
            back = (quot << 3) + (quot << 1);
        end
        diff       = i_req.dividend - back;
        o_rsp.quot = quot;
        o_rsp.rem  = diff[lclf_pkg::REM_BITS-1:0];
    end

endmodule

>>> rtl/lclf_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: splits the value into digits with the shared divider, then
// plays the characters out most significant first.
module lclf_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lclf_pkg::VALUE_BITS-1:0]     i_value,
    input  logic [lclf_pkg::STYLE_BITS-1:0]     i_style,
    input  logic                                i_sync,
    output lclf_pkg::t_div_req                  o_div_req,
    input  lclf_pkg::t_div_rsp                  i_div_rsp,
    output logic                                o_busy,
    output logic                                o_valid,
    output logic [lclf_pkg::CODE_BITS-1:0]      o_code,
    output logic                                o_last,
    output logic                                o_empty
);

    lclf_pkg::t_state                   r_state, n_state;
    lclf_pkg::t_mode                    r_mode, n_mode;
    logic                               r_upper, n_upper;
    logic [lclf_pkg::VALUE_BITS-1:0]    r_x, n_x;
    logic [lclf_pkg::REM_BITS-1:0]      r_digit [lclf_pkg::DIGIT_SLOTS];
    logic [lclf_pkg::REM_BITS-1:0]      n_digit [lclf_pkg::DIGIT_SLOTS];
    logic [lclf_pkg::CNT_BITS-1:0]      r_cnt, n_cnt;
    logic [lclf_pkg::TH_BITS-1:0]       r_th, n_th;
    logic [lclf_pkg::REP_BITS-1:0]      r_rep, n_rep;
    logic [1:0]                         r_place, n_place;
    logic [1:0]                         r_j, n_j;
    logic [lclf_pkg::CODE_BITS-1:0]     r_base, n_base;
    logic                               r_valid, n_valid;
    logic [lclf_pkg::CODE_BITS-1:0]     r_code, n_code;
    logic                               r_last, n_last;
    logic                               r_empty, n_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lclf_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_mode  <= n_mode;
        r_upper <= n_upper;
        r_x     <= n_x;
        r_digit <= n_digit;
        r_cnt   <= n_cnt;
        r_th    <= n_th;
        r_rep   <= n_rep;
        r_place <= n_place;
        r_j     <= n_j;
        r_base  <= n_base;
        r_code  <= n_code;
        r_last  <= n_last;
        r_empty <= n_empty;
    end

    always_comb begin
        logic                              div26;
        logic [lclf_pkg::CNT_BITS-1:0]     cnt_dec;
        logic [lclf_pkg::SLOT_BITS-1:0]    rd_idx;
        logic [lclf_pkg::REM_BITS-1:0]     rd_digit;
        logic                              d0z;
        logic                              d1z;
        logic                              d2z;
        logic                              below_zero;
        logic [2:0]                        len;
        logic                              place_end;
        logic                              is_last;

        n_state = r_state;
        n_mode  = r_mode;
        n_upper = r_upper;
        n_x     = r_x;
        n_digit = r_digit;
        n_cnt   = r_cnt;
        n_th    = r_th;
        n_rep   = r_rep;
        n_place = r_place;
        n_j     = r_j;
        n_base  = r_base;
        n_valid = 1'b0;
        n_code  = r_code;
        n_last  = r_last;
        n_empty = r_empty;

        // Alphabetic counting works on n - 1.
        div26 = (r_mode == lclf_pkg::MODE_ALPHA) || (r_mode == lclf_pkg::MODE_SYNC);
        o_div_req.dividend = div26 ? (r_x - lclf_pkg::VALUE_BITS'(1)) : r_x;
        o_div_req.radix26  = div26;

        cnt_dec  = r_cnt - lclf_pkg::CNT_BITS'(1);
        rd_idx   = (r_state == lclf_pkg::ST_EMIT_ROMAN) ? lclf_pkg::SLOT_BITS'(r_place)
                                                        : cnt_dec[lclf_pkg::SLOT_BITS-1:0];
        rd_digit = r_digit[rd_idx];

        d0z = (r_digit[0] == '0);
        d1z = (r_digit[1] == '0);
        d2z = (r_digit[2] == '0);
        unique case (r_place)
            2'd2:    below_zero = d1z && d0z;
            2'd1:    below_zero = d0z;
            default: below_zero = 1'b1;
        endcase
        len       = lclf_pkg::roman_len(rd_digit);
        place_end = ({1'b0, r_j} == len - 3'd1);
        is_last   = 1'b0;

        unique case (r_state)
            lclf_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_x   = i_value;
                    n_cnt = '0;
                    if ((i_style == lclf_pkg::STYLE_LOWER_ALPHA) ||
                        (i_style == lclf_pkg::STYLE_UPPER_ALPHA)) begin
                        n_upper = (i_style == lclf_pkg::STYLE_UPPER_ALPHA);
                        n_base  = n_upper ? lclf_pkg::CODE_UPPER_A : lclf_pkg::CODE_LOWER_A;
                        if (i_value == '0) begin
                            n_valid = 1'b1;
                            n_code  = n_base - lclf_pkg::CODE_BITS'(1);
                            n_last  = 1'b1;
                            n_empty = 1'b0;
                        end else begin
                            n_mode  = i_sync ? lclf_pkg::MODE_SYNC : lclf_pkg::MODE_ALPHA;
                            n_state = lclf_pkg::ST_DIV;
                        end
                    end else if ((i_style == lclf_pkg::STYLE_LOWER_ROMAN) ||
                                 (i_style == lclf_pkg::STYLE_UPPER_ROMAN)) begin
                        n_upper = (i_style == lclf_pkg::STYLE_UPPER_ROMAN);
                        if (i_value == '0) begin
                            n_valid = 1'b1;
                            n_code  = lclf_pkg::CODE_ZERO;
                            n_last  = 1'b1;
                            n_empty = 1'b0;
                        end else begin
                            n_mode  = lclf_pkg::MODE_ROMAN;
                            n_state = lclf_pkg::ST_DIV;
                        end
                    end else if ((i_style >= lclf_pkg::STYLE_BENGALI) &&
                                 (i_style <= lclf_pkg::STYLE_THAI)) begin
                        n_base = lclf_pkg::script_zero(i_style);
                        if (i_value == '0) begin
                            n_valid = 1'b1;
                            n_code  = '0;
                            n_last  = 1'b1;
                            n_empty = 1'b1;
                        end else begin
                            n_mode  = lclf_pkg::MODE_DIGITS;
                            n_state = lclf_pkg::ST_DIV;
                        end
                    end else begin
                        n_base  = lclf_pkg::CODE_ZERO;
                        n_mode  = lclf_pkg::MODE_DIGITS;
                        n_state = lclf_pkg::ST_DIV;
                    end
                end
            end

            lclf_pkg::ST_DIV: begin
                n_digit[r_cnt[lclf_pkg::SLOT_BITS-1:0]] = i_div_rsp.rem;
                n_cnt = r_cnt + lclf_pkg::CNT_BITS'(1);
                n_x   = i_div_rsp.quot;
                unique case (r_mode)
                    lclf_pkg::MODE_SYNC: begin
                        if (32'(i_div_rsp.quot) >= 32'(lclf_pkg::MAX_RESULTS)) begin
                            n_rep = lclf_pkg::REP_BITS'(lclf_pkg::MAX_RESULTS);
                        end else begin
                            n_rep = lclf_pkg::REP_BITS'(i_div_rsp.quot) +
                                    lclf_pkg::REP_BITS'(1);
                        end
                        n_state = lclf_pkg::ST_EMIT_REPEAT;
                    end
                    lclf_pkg::MODE_ROMAN: begin
                        if (r_cnt == lclf_pkg::CNT_BITS'(2)) begin
                            n_th    = lclf_pkg::TH_BITS'(i_div_rsp.quot);
                            n_place = 2'd2;
                            n_j     = 2'd0;
                            n_state = (i_div_rsp.quot != '0) ? lclf_pkg::ST_EMIT_THOUSANDS
                                                             : lclf_pkg::ST_EMIT_ROMAN;
                        end
                    end
                    default: begin
                        if (i_div_rsp.quot == '0) begin
                            n_state = lclf_pkg::ST_EMIT_DIGITS;
                        end
                    end
                endcase
            end

            lclf_pkg::ST_EMIT_DIGITS: begin
                is_last = (r_cnt == lclf_pkg::CNT_BITS'(1));
                n_valid = 1'b1;
                n_code  = r_base + lclf_pkg::CODE_BITS'(rd_digit);
                n_last  = is_last;
                n_empty = 1'b0;
                n_cnt   = cnt_dec;
                if (is_last) begin
                    n_state = lclf_pkg::ST_IDLE;
                end
            end

            lclf_pkg::ST_EMIT_REPEAT: begin
                is_last = (r_rep == lclf_pkg::REP_BITS'(1));
                n_valid = 1'b1;
                n_code  = r_base + lclf_pkg::CODE_BITS'(r_digit[0]);
                n_last  = is_last;
                n_empty = 1'b0;
                n_rep   = r_rep - lclf_pkg::REP_BITS'(1);
                if (is_last) begin
                    n_state = lclf_pkg::ST_IDLE;
                end
            end

            lclf_pkg::ST_EMIT_THOUSANDS: begin
                is_last = (r_th == lclf_pkg::TH_BITS'(1)) && d2z && d1z && d0z;
                n_valid = 1'b1;
                n_code  = r_upper ? (lclf_pkg::CODE_LOWER_M - lclf_pkg::CASE_SHIFT)
                                  : lclf_pkg::CODE_LOWER_M;
                n_last  = is_last;
                n_empty = 1'b0;
                n_th    = r_th - lclf_pkg::TH_BITS'(1);
                if (r_th == lclf_pkg::TH_BITS'(1)) begin
                    n_state = is_last ? lclf_pkg::ST_IDLE : lclf_pkg::ST_EMIT_ROMAN;
                end
            end

            lclf_pkg::ST_EMIT_ROMAN: begin
                if (len == 3'd0) begin
                    // An empty place gives no character; step down to the next one.
                    if (r_place == 2'd0) begin
                        n_state = lclf_pkg::ST_IDLE;
                    end else begin
                        n_place = r_place - 2'd1;
                    end
                end else begin
                    is_last = place_end && below_zero;
                    n_valid = 1'b1;
                    n_code  = lclf_pkg::roman_char(r_place,
                                                   lclf_pkg::roman_sym(rd_digit, r_j), r_upper);
                    n_last  = is_last;
                    n_empty = 1'b0;
                    if (place_end) begin
                        n_j = 2'd0;
                        if (is_last || (r_place == 2'd0)) begin
                            n_state = lclf_pkg::ST_IDLE;
                        end else begin
                            n_place = r_place - 2'd1;
                        end
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end
            end

            default: begin
                n_state = lclf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != lclf_pkg::ST_IDLE);
    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_last  = r_last;
    assign o_empty = r_empty;

endmodule

>>> rtl/list_counter_label_formatter_core.sv
`timescale 1ns / 1ps

// List counter label formatter. Raise start for one cycle while busy is low to
// hand in a counter value; the block answers with the label's characters, most
// significant first, one beat per cycle on o_char_strobe, and flags the final
// beat with o_last_char. There is no back-pressure: every beat is shown for
// exactly one cycle and must be taken then. A single shared divider (a
// reciprocal multiply by ten or by 26) splits the value into digits at one
// digit per cycle, and the characters then leave at one per cycle, but for a
// gap with no beat for each empty decimal place before a Roman label's final
// character. A decimal or script label takes one division per digit, a
// bijective letter label one per letter, a letter-sync label a single one
// before its repeats and a Roman label three. A zero value in a letter,
// Roman or script style gives its single beat in the cycle after acceptance
// and leaves busy low throughout; a zero in the decimal style, or in the
// unused style code, is an ordinary one-digit label. The style and
// letter-sync registers may be written only while no label is in progress.
module list_counter_label_formatter_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_cfg_we,
    input  logic [lclf_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [lclf_pkg::STYLE_BITS-1:0]         i_cfg_wdata,
    input  logic [lclf_pkg::VALUE_BITS-1:0]         i_counter_value,
    output logic                                    o_char_strobe,
    output logic [lclf_pkg::CODE_BITS-1:0]          o_char_code,
    output logic                                    o_last_char,
    output logic                                    o_empty_label
);

    // Configuration registers, written through the plain write port.
    logic [lclf_pkg::STYLE_BITS-1:0] r_label_style;
    logic                            r_letter_sync;

    // Link between the sequencer and the shared divider.
    lclf_pkg::t_div_req div_req;
    lclf_pkg::t_div_rsp div_rsp;

    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_style <= lclf_pkg::STYLE_DECIMAL;
            r_letter_sync <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lclf_pkg::CFG_LABEL_STYLE: r_label_style <= i_cfg_wdata;
                lclf_pkg::CFG_LETTER_SYNC: r_letter_sync <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // An item enters only when the sequencer has finished the previous label.
    assign accept = start && !busy;

    lclf_divu u_divu (
        .i_req (div_req),
        .o_rsp (div_rsp)
    );

    lclf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_value   (i_counter_value),
        .i_style   (r_label_style),
        .i_sync    (r_letter_sync),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_busy    (busy),
        .o_valid   (o_char_strobe),
        .o_code    (o_char_code),
        .o_last    (o_last_char),
        .o_empty   (o_empty_label)
    );

endmodule

>>> rtl/lclf_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the label formatter.
module lclf_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_char_strobe,
    input logic [lclf_pkg::CODE_BITS-1:0]       o_char_code,
    input logic                                 o_last_char,
    input logic                                 o_empty_label
);

    // An empty label is a single final beat carrying a zero code.
    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_strobe && o_empty_label |-> o_last_char && (o_char_code == '0))
        else $error("empty label beat is not a final zero beat");

    // A beat only follows a cycle with a label in progress or being accepted.
    a_no_spurious_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_strobe && $past(i_rst_n) |-> $past(busy) || $past(start))
        else $error("character beat without a label in progress");

    // The final beat of a label leaves the block free.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_strobe && o_last_char |-> !busy)
        else $error("busy still high on the final beat");

    // busy only falls together with the final beat.
    a_fall_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_char_strobe && o_last_char)
        else $error("busy fell without a final beat");

endmodule

bind list_counter_label_formatter_core lclf_checker u_lclf_checker (.*);
